@@ sv/swp_pkg.sv @@
// ----------------------------------------------------------------------------
// swp_pkg: shared types and constants of the stereo width and pan block
// Register codes, the configuration and pan control words, and the defaults
// for the top-level parameters.
// ----------------------------------------------------------------------------
package swp_pkg;

    localparam int DEF_SAMPLE_WIDTH     = 24;
    localparam int DEF_GAIN_FRAC_BITS   = 12;
    localparam int DEF_SINE_TABLE_DEPTH = 256;
    localparam int DEF_PAN_DEAD_ZONE    = 33;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Unity pan gain, Q1.15
    localparam logic [15:0] GAIN_UNITY = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_STEREO_WIDTH = 3'd1,
        REG_MID_GAIN     = 3'd2,
        REG_SIDE_GAIN    = 3'd3,
        REG_PAN_POSITION = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic               enable;
        logic [15:0]        stereo_width;
        logic [15:0]        mid_gain;
        logic [15:0]        side_gain;
        logic signed [15:0] pan_position;
    } cfg_t;

    typedef struct packed {
        logic        pan_on;
        logic        last;
        logic [15:0] gain_l;
        logic [15:0] gain_r;
    } pan_ctl_t;

endpackage

@@ sv/swp_if.sv @@
// ----------------------------------------------------------------------------
// swp_if: stream channels of the stereo width and pan block
// One channel for incoming stereo words, one for processed stereo words.
// ----------------------------------------------------------------------------
interface swp_in_if #(
    parameter int SAMPLE_WIDTH = swp_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
    logic                           last_frame;

    modport source (output valid, left_sample, right_sample, last_frame, input ready);
    modport sink   (input valid, left_sample, right_sample, last_frame, output ready);
endinterface

interface swp_out_if #(
    parameter int SAMPLE_WIDTH = swp_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           last_out;

    modport source (output valid, left_out, right_out, last_out, input ready);
    modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

@@ sv/swp_sine_rom.sv @@
// ----------------------------------------------------------------------------
// swp_sine_rom: quarter-sine gain table
// Q1.15 sine of i*pi/(2*depth) for i = 0..depth, built at elaboration;
// two read ports with registered data.
// ----------------------------------------------------------------------------
module swp_sine_rom #(
    parameter int SINE_TABLE_DEPTH = swp_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] sin_idx,
    input  logic [IDX_W-1:0] cos_idx,
    output logic [15:0]      sin_gain,
    output logic [15:0]      cos_gain
);
    import swp_pkg::*;

    // Eight-term Taylor series in Q30, rounded to Q15 and clamped to unity
    function automatic logic [15:0] qsine(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32768)
        begin
            r = 64'sd32768;
        end
        return r[15:0];
    endfunction

    logic [15:0] rom_w [0:SINE_TABLE_DEPTH];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++)
    begin : g_entry
        localparam logic [15:0] ENTRY = qsine(i);
        assign rom_w[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sin_gain <= rom_w[sin_idx];
            cos_gain <= rom_w[cos_idx];
        end
    end

endmodule

@@ sv/swp_matrix.sv @@
// ----------------------------------------------------------------------------
// swp_matrix: mid/side width matrix, stages one to three
// Form mid and side sums, scale them, decode and saturate; look up the
// pan gains alongside.
// ----------------------------------------------------------------------------
module swp_matrix #(
    parameter int SAMPLE_WIDTH     = swp_pkg::DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRAC_BITS   = swp_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SINE_TABLE_DEPTH = swp_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int PAN_DEAD_ZONE    = swp_pkg::DEF_PAN_DEAD_ZONE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swp_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
    input  logic                           last_frame,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] left_mix,
    output logic signed [SAMPLE_WIDTH-1:0] right_mix,
    output swp_pkg::pan_ctl_t              pan_ctl
);
    import swp_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int F     = GAIN_FRAC_BITS;
    localparam int GW    = 32 - F;
    localparam int PW    = SW + 35 - F;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPW   = 16 + IDX_W;

    localparam logic [GW-1:0]        G_ONE    = GW'(2 ** F);
    localparam logic [15:0]          MG_ONE   = 16'(2 ** F);
    localparam logic [32:0]          G_HALF   = 33'(2 ** (F - 1));
    localparam logic [IPW-1:0]       DEPTH_P  = IPW'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0]     DEPTH_I  = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic signed [16:0]   DZ_POS   = 17'(PAN_DEAD_ZONE);
    localparam logic signed [16:0]   DZ_NEG   = -DZ_POS;
    localparam logic signed [PW-1:0] RND      = PW'(1) << F;
    localparam logic signed [PW-1:0] SAT_HI   = (PW'(1) << (SW - 1)) - PW'(1);
    localparam logic signed [PW-1:0] SAT_LO   = -SAT_HI - PW'(1);

    // Stage occupancy and flow
    logic v1_reg, v2_reg, v3_reg;
    logic free1, free2, free3;

    assign free3    = !v3_reg || out_ready;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;

    // Stage 1: sums, combined side gain, pan table indices
    logic signed [SW:0]   m2_reg, s2_reg, m2_next, s2_next;
    logic [GW-1:0]        g_reg, g_next;
    logic [15:0]          mg_reg, mg_next;
    logic                 pan_on1_reg, pan_on1_next;
    logic                 last1_reg;
    logic [IDX_W-1:0]     sin_idx_reg, cos_idx_reg, sin_idx_next, cos_idx_next;
    logic [31:0]          g_prod;
    logic [32:0]          g_sum;
    logic [15:0]          pan_u;
    logic [IPW-1:0]       idx_prod;
    logic signed [16:0]   pan_x;
    logic                 in_zone;

    always_comb
    begin
        m2_next  = (SW + 1)'(left_sample) + (SW + 1)'(right_sample);
        s2_next  = (SW + 1)'(left_sample) - (SW + 1)'(right_sample);
        g_prod   = 32'(cfg.side_gain) * 32'(cfg.stereo_width);
        g_sum    = 33'(g_prod) + G_HALF;
        pan_x    = {cfg.pan_position[15], cfg.pan_position};
        in_zone  = (pan_x < DZ_POS) && (pan_x > DZ_NEG);
        pan_u    = {~cfg.pan_position[15], cfg.pan_position[14:0]};
        idx_prod = IPW'(pan_u) * DEPTH_P;
        sin_idx_next = idx_prod[16 +: IDX_W];
        cos_idx_next = DEPTH_I - idx_prod[16 +: IDX_W];
        // With unity gains the matrix returns the input exactly: bypass
        if (cfg.enable)
        begin
            g_next       = g_sum[F +: GW];
            mg_next      = cfg.mid_gain;
            pan_on1_next = !in_zone;
        end
        else
        begin
            g_next       = G_ONE;
            mg_next      = MG_ONE;
            pan_on1_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (free1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            m2_reg      <= m2_next;
            s2_reg      <= s2_next;
            g_reg       <= g_next;
            mg_reg      <= mg_next;
            pan_on1_reg <= pan_on1_next;
            last1_reg   <= last_frame;
            sin_idx_reg <= sin_idx_next;
            cos_idx_reg <= cos_idx_next;
        end
    end

    // Stage 2: the two gain products and the table read
    logic signed [SW+17:0]   mp_reg, mp_next;
    logic signed [SW+GW+1:0] sp_reg, sp_next;
    logic                    pan_on2_reg, last2_reg;
    logic [15:0]             sin_gain, cos_gain;

    assign mp_next = m2_reg * $signed({1'b0, mg_reg});
    assign sp_next = s2_reg * $signed({1'b0, g_reg});

    swp_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .IDX_W            (IDX_W)
    ) u_rom (
        .clk      (clk),
        .rd_en    (free2),
        .sin_idx  (sin_idx_reg),
        .cos_idx  (cos_idx_reg),
        .sin_gain (sin_gain),
        .cos_gain (cos_gain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (free2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            mp_reg      <= mp_next;
            sp_reg      <= sp_next;
            pan_on2_reg <= pan_on1_reg;
            last2_reg   <= last1_reg;
        end
    end

    // Stage 3: decode, round half up, saturate
    logic signed [PW-1:0] sum_l, sum_r, sh_l, sh_r;
    logic signed [SW-1:0] left3_reg, right3_reg, left3_next, right3_next;
    pan_ctl_t             ctl3_reg;

    always_comb
    begin
        sum_l = PW'(mp_reg) + PW'(sp_reg) + RND;
        sum_r = PW'(mp_reg) - PW'(sp_reg) + RND;
        sh_l  = sum_l >>> (F + 1);
        sh_r  = sum_r >>> (F + 1);
        if (sh_l > SAT_HI)
        begin
            left3_next = SAT_HI[SW-1:0];
        end
        else if (sh_l < SAT_LO)
        begin
            left3_next = SAT_LO[SW-1:0];
        end
        else
        begin
            left3_next = sh_l[SW-1:0];
        end
        if (sh_r > SAT_HI)
        begin
            right3_next = SAT_HI[SW-1:0];
        end
        else if (sh_r < SAT_LO)
        begin
            right3_next = SAT_LO[SW-1:0];
        end
        else
        begin
            right3_next = sh_r[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (free3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            left3_reg       <= left3_next;
            right3_reg      <= right3_next;
            ctl3_reg.pan_on <= pan_on2_reg;
            ctl3_reg.last   <= last2_reg;
            ctl3_reg.gain_l <= cos_gain;
            ctl3_reg.gain_r <= sin_gain;
        end
    end

    assign out_valid = v3_reg;
    assign left_mix  = left3_reg;
    assign right_mix = right3_reg;
    assign pan_ctl   = ctl3_reg;

    // A stalled decoded word must survive until taken
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_ready |=> v3_reg && $stable(left3_reg) && $stable(right3_reg))
        else $error("stage 3 word changed while stalled");

    // A stalled stage-1 word must not be overwritten
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !free2 |=> v1_reg && $stable(m2_reg) && $stable(s2_reg))
        else $error("stage 1 word changed while stalled");

    // Back-pressure only when every stage is full
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && !out_ready)
        else $error("input stalled with a bubble in the pipeline");

    // Table gains never exceed unity
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> ctl3_reg.gain_l <= GAIN_UNITY && ctl3_reg.gain_r <= GAIN_UNITY)
        else $error("pan gain above unity");

endmodule

@@ sv/swp_pan.sv @@
// ----------------------------------------------------------------------------
// swp_pan: equal-power pan, stage four and output register
// Scale each side by its table gain if pan_on, round half up, hold the result.
// ----------------------------------------------------------------------------
module swp_pan #(
    parameter int SAMPLE_WIDTH = swp_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_mix,
    input  logic signed [SAMPLE_WIDTH-1:0] right_mix,
    input  swp_pkg::pan_ctl_t              pan_ctl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out,
    output logic                           last_out
);
    import swp_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam logic signed [SW+16:0] RND15 = (SW + 17)'(16384);

    logic                 v4_reg;
    logic                 free4;
    logic signed [SW+16:0] prod_l, prod_r, rnd_l, rnd_r;
    logic signed [SW-1:0] left4_reg, right4_reg, left4_next, right4_next;
    logic                 last4_reg;

    assign free4    = !v4_reg || out_ready;
    assign in_ready = free4;

    always_comb
    begin
        prod_l = left_mix * $signed({1'b0, pan_ctl.gain_l});
        prod_r = right_mix * $signed({1'b0, pan_ctl.gain_r});
        rnd_l  = (prod_l + RND15) >>> 15;
        rnd_r  = (prod_r + RND15) >>> 15;
        if (pan_ctl.pan_on)
        begin
            left4_next  = rnd_l[SW-1:0];
            right4_next = rnd_r[SW-1:0];
        end
        else
        begin
            left4_next  = left_mix;
            right4_next = right_mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (free4)
        begin
            v4_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free4)
        begin
            left4_reg  <= left4_next;
            right4_reg <= right4_next;
            last4_reg  <= pan_ctl.last;
        end
    end

    assign out_valid = v4_reg;
    assign left_out  = left4_reg;
    assign right_out = right4_reg;
    assign last_out  = last4_reg;

endmodule

@@ sv/stereo_width_and_pan.sv @@
// ----------------------------------------------------------------------------
// stereo_width_and_pan: mid/side stereo width with equal-power pan
// Top level: configuration registers and the four-stage frame pipeline.
// ----------------------------------------------------------------------------
// One stereo word enters per clock and one processed word leaves per clock
// while the result channel is ready; each word passes in order through the
// four register stages: sum and side-gain product, the mid and side gain
// multipliers with the sine table read, decode and saturation, and the pan
// multipliers feeding the output register. Back-pressure on the result
// channel stalls the stages from the back, empty stages fill first, so input
// is still taken while a finished word waits. Registers are written through
// cfg_we/cfg_index/cfg_data, take effect on the next word, and must be
// written only while no word is in flight; indices past the register list
// are ignored. With enable low the samples pass through unchanged; inside
// the centre dead zone of the pan the pan gains are skipped.
module stereo_width_and_pan #(
    parameter int SAMPLE_WIDTH     = swp_pkg::DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRAC_BITS   = swp_pkg::DEF_GAIN_FRAC_BITS,
    parameter int SINE_TABLE_DEPTH = swp_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int PAN_DEAD_ZONE    = swp_pkg::DEF_PAN_DEAD_ZONE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0]    cfg_data,
    swp_in_if.sink                            samples,
    swp_out_if.source                         results
);
    import swp_pkg::*;

    // Configuration registers; hold reset values until written
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:       cfg_next.enable       = cfg_data[0];
                REG_STEREO_WIDTH: cfg_next.stereo_width = cfg_data;
                REG_MID_GAIN:     cfg_next.mid_gain     = cfg_data;
                REG_SIDE_GAIN:    cfg_next.side_gain    = cfg_data;
                REG_PAN_POSITION: cfg_next.pan_position = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b1;
            cfg_reg.stereo_width <= 16'd4096;
            cfg_reg.mid_gain     <= 16'd4096;
            cfg_reg.side_gain    <= 16'd4096;
            cfg_reg.pan_position <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stages one to three: width matrix and table lookup
    logic                           mix_valid, mix_ready;
    logic signed [SAMPLE_WIDTH-1:0] left_mix, right_mix;
    pan_ctl_t                       pan_ctl;

    swp_matrix #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PAN_DEAD_ZONE    (PAN_DEAD_ZONE)
    ) u_matrix (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (samples.valid),
        .in_ready     (samples.ready),
        .left_sample  (samples.left_sample),
        .right_sample (samples.right_sample),
        .last_frame   (samples.last_frame),
        .out_valid    (mix_valid),
        .out_ready    (mix_ready),
        .left_mix     (left_mix),
        .right_mix    (right_mix),
        .pan_ctl      (pan_ctl)
    );

    // Stage four: pan gains and the output register
    swp_pan #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .left_mix  (left_mix),
        .right_mix (right_mix),
        .pan_ctl   (pan_ctl),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .left_out  (results.left_out),
        .right_out (results.right_out),
        .last_out  (results.last_out)
    );

endmodule
